FILE: src/lrf_pkg.sv
// Shared types and constants of the layered ring FIFO.
package lrf_pkg;

   // Default geometry, handed down by the top level.
   localparam int unsigned DEPTH_DEFAULT       = 256;
   localparam int unsigned ENTRY_WIDTH_DEFAULT = 64;
   localparam int unsigned BATCH_MAX_DEFAULT   = 64;

   // Command queue between the front and the back.
   localparam int unsigned CMDQ_DEPTH = 2;

   // Field widths of the channels.
   localparam int unsigned DATA_W     = 64;
   localparam int unsigned LAYER_W    = 2;
   localparam int unsigned OCC_OUT_W  = 9;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned CLEAR_W    = 9;
   localparam int unsigned MAXB_W     = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 9;

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BATCH   = 2'd1;

   localparam logic [CLEAR_W-1:0] CLEAR_LEVEL_RESET = 9'd192;
   localparam logic [MAXB_W-1:0]  MAX_BATCH_RESET   = 7'd32;

   // Operation codes and the skip layer.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;
   localparam logic [LAYER_W-1:0] LAYER_SKIP = 2'd3;

   typedef enum logic [2:0] {
      ST_WRITTEN    = 3'd0,
      ST_DROPPED    = 3'd1,
      ST_SKIPPED    = 3'd2,
      ST_READ_ENTRY = 3'd3,
      ST_READ_EMPTY = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_SKIP,
      CMD_READ
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_BURST
   } back_state_type;

   typedef struct packed {
      logic               operation;
      logic [DATA_W-1:0]  edge_data;
      logic [LAYER_W-1:0] layer;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [DATA_W-1:0]    read_data;
      logic                 last;
      logic [OCC_OUT_W-1:0] occupancy;
      logic                 backpressure;
      logic [COUNT_W-1:0]   written_count;
      logic [COUNT_W-1:0]   consumed_count;
      logic [COUNT_W-1:0]   dropped_count;
      logic [COUNT_W-1:0]   hot_count;
      logic [COUNT_W-1:0]   warm_count;
      logic [COUNT_W-1:0]   cold_count;
      logic [COUNT_W-1:0]   skip_count;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [LAYER_W-1:0] layer;
      logic [DATA_W-1:0]  edge_data;
   } cmd_type;

endpackage

FILE: src/lrf_front.sv
// Front end: takes requests, classifies them and queues the commands.
module lrf_front import lrf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd
);

   localparam int unsigned QA_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int unsigned QC_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type           queue_ff [CMDQ_DEPTH];
   logic [QA_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]   count_ff, count_in;
   cmd_type           cls;
   logic              push, pop;

   // Classify the incoming request.
   always_comb begin
      cls.layer     = req_data.layer;
      cls.edge_data = req_data.edge_data;
      if (req_data.operation == OP_READ) begin
         cls.kind = CMD_READ;
      end else if (req_data.layer == LAYER_SKIP) begin
         cls.kind = CMD_SKIP;
      end else begin
         cls.kind = CMD_WRITE;
      end
   end

   assign req_stall = (count_ff == QC_W'(CMDQ_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QA_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QA_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: src/lrf_back.sv
// Back end: ring storage, pointers, counters, batch reads and the result register.
module lrf_back import lrf_pkg::*; #(
   parameter int unsigned DEPTH       = DEPTH_DEFAULT,
   parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEFAULT,
   parameter int unsigned BATCH_MAX   = BATCH_MAX_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  cmd_type               cmd,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
   localparam int unsigned BCNT_W = $clog2(BATCH_MAX + 1);

   logic [ENTRY_WIDTH-1:0] mem [DEPTH];
   logic [ENTRY_WIDTH-1:0] rdata_ff;

   back_state_type       state_ff, state_in;
   logic [ADDR_W-1:0]    wslot_ff, wslot_in;
   logic [ADDR_W-1:0]    rslot_ff, rslot_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic                 bp_ff, bp_in;
   logic [COUNT_W-1:0]   written_ff, written_in;
   logic [COUNT_W-1:0]   consumed_ff, consumed_in;
   logic [COUNT_W-1:0]   dropped_ff, dropped_in;
   logic [COUNT_W-1:0]   layer_ff [4];
   logic [COUNT_W-1:0]   layer_in [4];
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [BCNT_W-1:0]    remain_ff, remain_in;
   logic                 dval_ff, dval_in;
   logic                 dlast_ff, dlast_in;
   rsp_type              snap_ff, snap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [CLEAR_W-1:0]   clear_ff;
   logic [MAXB_W-1:0]    max_batch_ff;

   logic                 out_free, data_free;
   logic                 mem_we, mem_re;
   logic                 layer_inc, emit_now, snap_load;
   status_type           emit_status;
   logic [31:0]          lim, count32, rsum_raw, occ32;
   logic [ADDR_W-1:0]    rslot_adv, wslot_adv, addr_adv;
   logic [OCC_W-1:0]     occ_inc;
   rsp_type              tmpl;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign data_free = !dval_ff || out_free;

   // Batch size: max_batch saturated to BATCH_MAX, then bounded by occupancy.
   assign lim     = (32'(max_batch_ff) > 32'(BATCH_MAX)) ? 32'(BATCH_MAX)
                                                          : 32'(max_batch_ff);
   assign count32 = (32'(occ_ff) < lim) ? 32'(occ_ff) : lim;

   assign rsum_raw  = 32'(rslot_ff) + count32;
   assign rslot_adv = (rsum_raw >= 32'(DEPTH)) ? ADDR_W'(rsum_raw - 32'(DEPTH))
                                               : ADDR_W'(rsum_raw);
   assign wslot_adv = (wslot_ff == ADDR_W'(DEPTH - 1)) ? '0 : wslot_ff + 1'b1;
   assign addr_adv  = (addr_ff == ADDR_W'(DEPTH - 1)) ? '0 : addr_ff + 1'b1;
   assign occ_inc   = occ_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      wslot_in    = wslot_ff;
      rslot_in    = rslot_ff;
      occ_in      = occ_ff;
      bp_in       = bp_ff;
      written_in  = written_ff;
      consumed_in = consumed_ff;
      dropped_in  = dropped_ff;
      addr_in     = addr_ff;
      remain_in   = remain_ff;
      dval_in     = dval_ff && !out_free;
      dlast_in    = dlast_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      cmd_ready   = 1'b0;
      layer_inc   = 1'b0;
      emit_now    = 1'b0;
      snap_load   = 1'b0;
      emit_status = ST_WRITTEN;

      unique case (state_ff)
         BK_IDLE: begin
            // Wait for the read data stage to drain so results keep their order.
            if (cmd_valid && !dval_ff && out_free) begin
               cmd_ready = 1'b1;
               unique case (cmd.kind)
                  CMD_SKIP: begin
                     layer_inc   = 1'b1;
                     emit_now    = 1'b1;
                     emit_status = ST_SKIPPED;
                  end
                  CMD_WRITE: begin
                     layer_inc = 1'b1;
                     emit_now  = 1'b1;
                     if (occ_ff == OCC_W'(DEPTH)) begin
                        dropped_in  = dropped_ff + 1'b1;
                        bp_in       = 1'b1;
                        emit_status = ST_DROPPED;
                     end else begin
                        mem_we      = 1'b1;
                        wslot_in    = wslot_adv;
                        occ_in      = occ_inc;
                        written_in  = written_ff + 1'b1;
                        emit_status = ST_WRITTEN;
                        if (bp_ff && (32'(occ_inc) < 32'(clear_ff))) begin
                           bp_in = 1'b0;
                        end
                     end
                  end
                  CMD_READ: begin
                     if (count32 == '0) begin
                        emit_now    = 1'b1;
                        emit_status = ST_READ_EMPTY;
                     end else begin
                        // State moves at batch start; every entry shows the after-step view.
                        rslot_in    = rslot_adv;
                        occ_in      = occ_ff - OCC_W'(count32);
                        consumed_in = consumed_ff + count32;
                        addr_in     = rslot_ff;
                        remain_in   = BCNT_W'(count32);
                        snap_load   = 1'b1;
                        state_in    = BK_BURST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_BURST: begin
            if (data_free) begin
               mem_re    = 1'b1;
               addr_in   = addr_adv;
               remain_in = remain_ff - 1'b1;
               dval_in   = 1'b1;
               dlast_in  = (remain_ff == BCNT_W'(1));
               if (remain_ff == BCNT_W'(1)) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      for (int i = 0; i < 4; i++) begin
         layer_in[i] = layer_ff[i];
         if (layer_inc && (cmd.layer == LAYER_W'(i))) begin
            layer_in[i] = layer_ff[i] + 1'b1;
         end
      end
   end

   assign occ32 = 32'(occ_in);

   // Result template built from the state after this step.
   always_comb begin
      tmpl.status         = emit_status;
      tmpl.read_data      = '0;
      tmpl.last           = 1'b1;
      tmpl.occupancy      = occ32[OCC_OUT_W-1:0];
      tmpl.backpressure   = bp_in;
      tmpl.written_count  = written_in;
      tmpl.consumed_count = consumed_in;
      tmpl.dropped_count  = dropped_in;
      tmpl.hot_count      = layer_in[0];
      tmpl.warm_count     = layer_in[1];
      tmpl.cold_count     = layer_in[2];
      tmpl.skip_count     = layer_in[3];

      snap_in = snap_load ? tmpl : snap_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      priority if (dval_ff && out_free) begin
         rsp_data_in           = snap_ff;
         rsp_data_in.status    = ST_READ_ENTRY;
         rsp_data_in.read_data = DATA_W'(rdata_ff);
         rsp_data_in.last      = dlast_ff;
         rsp_valid_in          = 1'b1;
      end else if (emit_now) begin
         rsp_data_in  = tmpl;
         rsp_valid_in = 1'b1;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         wslot_ff     <= '0;
         rslot_ff     <= '0;
         occ_ff       <= '0;
         bp_ff        <= 1'b0;
         written_ff   <= '0;
         consumed_ff  <= '0;
         dropped_ff   <= '0;
         for (int i = 0; i < 4; i++) begin
            layer_ff[i] <= '0;
         end
         addr_ff      <= '0;
         remain_ff    <= '0;
         dval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clear_ff     <= CLEAR_LEVEL_RESET;
         max_batch_ff <= MAX_BATCH_RESET;
      end else begin
         state_ff     <= state_in;
         wslot_ff     <= wslot_in;
         rslot_ff     <= rslot_in;
         occ_ff       <= occ_in;
         bp_ff        <= bp_in;
         written_ff   <= written_in;
         consumed_ff  <= consumed_in;
         dropped_ff   <= dropped_in;
         for (int i = 0; i < 4; i++) begin
            layer_ff[i] <= layer_in[i];
         end
         addr_ff      <= addr_in;
         remain_ff    <= remain_in;
         dval_ff      <= dval_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            priority if (csr_index == CSR_CLEAR_LEVEL) begin
               clear_ff <= csr_data[CLEAR_W-1:0];
            end else if (csr_index == CSR_MAX_BATCH) begin
               max_batch_ff <= csr_data[MAXB_W-1:0];
            end else begin
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dlast_ff    <= dlast_in;
      snap_ff     <= snap_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Ring storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wslot_ff] <= cmd.edge_data[ENTRY_WIDTH-1:0];
      end
      if (mem_re) begin
         rdata_ff <= mem[addr_ff];
      end
   end

endmodule

FILE: src/layered_ring_fifo_with_backpressure.sv
// Layered ring FIFO of edge records with backpressure: top level.
//
// Requests enter through a two-entry command queue and are carried out by a
// back end that owns the ring memory and all counters; results leave through
// one output register, so a new request is taken while a result waits. Writes
// and skips sustain one per cycle unless the result side stalls. A read of n
// entries holds the back end to take the command, read each entry on the
// single memory read port and drain the read data register; an empty read
// gives one result. Every result of a batch shows the occupancy, backpressure
// flag and counters after the whole batch. The csr port is always ready; the
// user must write it only while idle, which the block does not enforce.
module layered_ring_fifo_with_backpressure import lrf_pkg::*; #(
   parameter int unsigned DEPTH       = DEPTH_DEFAULT,
   parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEFAULT,
   parameter int unsigned BATCH_MAX   = BATCH_MAX_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   lrf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   lrf_back #(
      .DEPTH       (DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .BATCH_MAX   (BATCH_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sim/lrf_checker.sv
// Scoreboard for the layered ring FIFO: tracks the ring state and checks every result transfer.
module lrf_checker import lrf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    failures,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PTR_W       = $clog2(2 * DEPTH_DEFAULT);
   localparam int unsigned REPORT_MAX  = 10;

   logic [DATA_W-1:0]  ring_mem [DEPTH_DEFAULT];
   logic [PTR_W-1:0]   head_ptr;
   logic [PTR_W-1:0]   tail_ptr;
   logic               bp_flag;
   logic [COUNT_W-1:0] written_total;
   logic [COUNT_W-1:0] consumed_total;
   logic [COUNT_W-1:0] dropped_total;
   logic [COUNT_W-1:0] layer_total [4];
   logic [CLEAR_W-1:0] clear_level;
   logic [MAXB_W-1:0]  batch_limit;
   rsp_type            ring_results_due [$];

   function automatic rsp_type snapshot(status_type st, logic [DATA_W-1:0] data, logic last);
      rsp_type r;
      r.status         = st;
      r.read_data      = data;
      r.last           = last;
      r.occupancy      = OCC_OUT_W'(head_ptr - tail_ptr);
      r.backpressure   = bp_flag;
      r.written_count  = written_total;
      r.consumed_count = consumed_total;
      r.dropped_count  = dropped_total;
      r.hot_count      = layer_total[0];
      r.warm_count     = layer_total[1];
      r.cold_count     = layer_total[2];
      r.skip_count     = layer_total[3];
      return r;
   endfunction

   function automatic string describe(rsp_type r);
      return {$sformatf("st=%0d data=%h last=%b occ=%0d bp=%b ",
                        r.status, r.read_data, r.last, r.occupancy, r.backpressure),
              $sformatf("wr=%0d rd=%0d drop=%0d lay=%0d/%0d/%0d/%0d",
                        r.written_count, r.consumed_count, r.dropped_count,
                        r.hot_count, r.warm_count, r.cold_count, r.skip_count)};
   endfunction

   task automatic model_ring_request(req_type rq);
      logic [PTR_W-1:0] fill;
      logic [PTR_W-1:0] start;
      int unsigned      lim;
      int unsigned      count;
      status_type       st;
      fill = head_ptr - tail_ptr;
      if (rq.operation == OP_WRITE) begin
         if (rq.layer == LAYER_SKIP) begin
            layer_total[LAYER_SKIP]++;
            st = ST_SKIPPED;
         end else if (fill >= DEPTH_DEFAULT) begin
            // full ring: record is lost but its layer still counts
            dropped_total++;
            bp_flag = 1'b1;
            layer_total[rq.layer]++;
            st = ST_DROPPED;
         end else begin
            ring_mem[head_ptr % DEPTH_DEFAULT] = rq.edge_data;
            head_ptr++;
            if (bp_flag && (PTR_W'(head_ptr - tail_ptr) < clear_level))
               bp_flag = 1'b0;
            written_total++;
            layer_total[rq.layer]++;
            st = ST_WRITTEN;
         end
         ring_results_due.push_back(snapshot(st, '0, 1'b1));
      end else begin
         lim   = (batch_limit > BATCH_MAX_DEFAULT) ? BATCH_MAX_DEFAULT : batch_limit;
         count = (fill < lim) ? fill : lim;
         if (count == 0) begin
            ring_results_due.push_back(snapshot(ST_READ_EMPTY, '0, 1'b1));
         end else begin
            // every beat of the batch reports the state after the whole batch
            start          = tail_ptr;
            tail_ptr       = tail_ptr + PTR_W'(count);
            consumed_total = consumed_total + count;
            for (int unsigned i = 0; i < count; i++)
               ring_results_due.push_back(snapshot(ST_READ_ENTRY,
                                                   ring_mem[(start + i) % DEPTH_DEFAULT],
                                                   i + 1 == count));
         end
      end
   endtask

   task automatic check_result(rsp_type act);
      rsp_type exp;
      string   bad;
      if (ring_results_due.size() == 0) begin
         failures++;
         if (failures <= REPORT_MAX)
            $display("unexpected result transfer: %s", describe(act));
      end else begin
         exp = ring_results_due.pop_front();
         bad = "";
         if (exp.status !== act.status)                 bad = {bad, " status"};
         if (exp.read_data !== act.read_data)           bad = {bad, " read_data"};
         if (exp.last !== act.last)                     bad = {bad, " last"};
         if (exp.occupancy !== act.occupancy)           bad = {bad, " occupancy"};
         if (exp.backpressure !== act.backpressure)     bad = {bad, " backpressure"};
         if (exp.written_count !== act.written_count)   bad = {bad, " written_count"};
         if (exp.consumed_count !== act.consumed_count) bad = {bad, " consumed_count"};
         if (exp.dropped_count !== act.dropped_count)   bad = {bad, " dropped_count"};
         if (exp.hot_count !== act.hot_count)           bad = {bad, " hot_count"};
         if (exp.warm_count !== act.warm_count)         bad = {bad, " warm_count"};
         if (exp.cold_count !== act.cold_count)         bad = {bad, " cold_count"};
         if (exp.skip_count !== act.skip_count)         bad = {bad, " skip_count"};
         if (bad != "") begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("mismatch at %0t in%s", $realtime, bad);
               $display("  expected %s", describe(exp));
               $display("  actual   %s", describe(act));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_ptr       = '0;
         tail_ptr       = '0;
         bp_flag        = 1'b0;
         written_total  = '0;
         consumed_total = '0;
         dropped_total  = '0;
         foreach (layer_total[i])
            layer_total[i] = '0;
         clear_level    = CLEAR_LEVEL_RESET;
         batch_limit    = MAX_BATCH_RESET;
         ring_results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_CLEAR_LEVEL: clear_level = csr_data[CLEAR_W-1:0];
               CSR_MAX_BATCH:   batch_limit = csr_data[MAXB_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            model_ring_request(req_data);
         if (rsp_valid && !rsp_stall)
            check_result(rsp_data);
      end
      pending = ring_results_due.size();
   end

endmodule

FILE: sim/tb_top.sv
// Top of the layered ring FIFO testbench: clock, reset, stimulus and verdict.
module tb_top import lrf_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RUN_LIMIT    = 400000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned SETTLE_GAP   = 8;
   localparam int unsigned DRAIN_CYCLES = 70;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_CLEAR_LEVEL;
   logic [CSR_DATA_W-1:0] csr_data  = '0;
   int                    failures;
   int                    pending;
   int unsigned           tx_idle_pct = 17;
   int unsigned           rx_idle_pct = 58;
   bit                    hold_rsp    = 1'b0;
   int unsigned           cycle_count = 0;

   layered_ring_fifo_with_backpressure u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   lrf_checker u_chk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stall, or a long hold-off when asked for
   always begin
      @(negedge clock);
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_rsp = 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   function automatic logic [DATA_W-1:0] random_edge();
      return {$urandom, $urandom};
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic offer(input req_type item);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic offer_mixed(int unsigned write_pct, int unsigned n);
      repeat (n) begin
         if ($urandom_range(99) < write_pct)
            offer(req_type'{OP_WRITE, random_edge(), LAYER_W'($urandom_range(3))});
         else
            offer(req_type'{OP_READ, random_edge(), LAYER_W'($urandom_range(3))});
      end
   endtask

   task automatic fill_ring(int unsigned n);
      repeat (n)
         offer(req_type'{OP_WRITE, random_edge(), LAYER_W'($urandom_range(2))});
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      // empty reads also report a result; leave the back end some slack
      repeat (SETTLE_GAP) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic reconfigure(logic [CSR_DATA_W-1:0] level, logic [CSR_DATA_W-1:0] batch);
      settle();
      write_csr(CSR_CLEAR_LEVEL, level);
      write_csr(CSR_MAX_BATCH, batch);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, empty read, each layer, data extremes
      offer(req_type'{OP_READ, '0, 2'd0});
      offer(req_type'{OP_WRITE, '0, 2'd0});
      offer(req_type'{OP_WRITE, '1, 2'd1});
      offer(req_type'{OP_WRITE, 64'h8000_0000_0000_0001, 2'd2});
      offer(req_type'{OP_WRITE, '1, LAYER_SKIP});
      offer(req_type'{OP_READ, '1, LAYER_SKIP});
      offer(req_type'{OP_READ, '0, 2'd0});
      fill_ring(5);
      offer(req_type'{OP_WRITE, 64'h5555_aaaa_5555_aaaa, LAYER_SKIP});
      offer(req_type'{OP_READ, random_edge(), 2'd1});
      offer(req_type'{OP_READ, random_edge(), 2'd2});

      // zero batch: every read comes back empty while the ring grows
      reconfigure(9'd0, 9'd0);
      offer_mixed(60, 15);

      // batch above the cap saturates; upper data bits ignored
      reconfigure(9'd100, 9'h1FF);
      offer_mixed(70, 15);

      // fill past full with the result side held off for a while
      reconfigure(9'd256, 9'd1);
      tx_idle_pct = 58;
      rx_idle_pct = 17;
      hold_rsp    = 1'b1;
      fill_ring(265);
      offer_mixed(50, 10);

      // clear level above depth: any accepted write drops backpressure
      reconfigure(9'd511, 9'd64);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      offer_mixed(45, 20);

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: layered_ring_fifo_with_backpressure.f
src/lrf_pkg.sv
src/lrf_front.sv
src/lrf_back.sv
src/layered_ring_fifo_with_backpressure.sv
sim/lrf_checker.sv
sim/tb_top.sv
